>>> sv/ptbd_pkg.sv
// Package for the prefix tree bit decoder: word types, node layout and op codes.
// Used by prefix_tree_bit_decoder; depends on nothing.
package ptbd_pkg;

    localparam int SYMBOLS_DEF = 256;
    localparam int INDEX_W     = 9;
    localparam int SYM_W       = 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic               op;
        logic [INDEX_W-1:0] node_index;
        logic               node_is_leaf;
        logic [SYM_W-1:0]   node_symbol;
        logic [INDEX_W-1:0] left_index;
        logic [INDEX_W-1:0] right_index;
        logic               code_bit;
        logic               last_bit;
    } cmd_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             message_end;
        logic             incomplete;
    } res_t;

    typedef struct packed {
        logic               leaf;
        logic [SYM_W-1:0]   symbol;
        logic [INDEX_W-1:0] left;
        logic [INDEX_W-1:0] right;
    } node_t;

    localparam int NODE_W = $bits(node_t);

endpackage

>>> sv/prefix_tree_bit_decoder.sv
// Prefix tree bit decoder: one code bit or one node write per cycle while the queue has room.
// The final bit of a word is registered into the resolve stage, which then queues the result word.
// Each code bit issues at most one node-table read.
// Reset: the walk returns to the root and the result queue empties; the node table holds
// no defined contents until written, and there is no clearing pass.
// Depends on ptbd_pkg and ptbd_ram.
module prefix_tree_bit_decoder #(
    parameter int SYMBOLS = ptbd_pkg::SYMBOLS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  ptbd_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output ptbd_pkg::res_t res
);

    import ptbd_pkg::*;

    // The table holds every node of a full binary tree over SYMBOLS leaves.
    localparam int TABLE_SIZE = 2 * SYMBOLS - 1;
    localparam int ADDR_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    // Results wait in a three-word queue. That leaves room for the word now in
    // the resolve stage and the word accepted this cycle, so input keeps
    // flowing while the output side holds one word.
    localparam int QDEPTH = 3;
    localparam int QPTR_W = 2;

    // The walk is a two-stage loop around the node table. In the accept cycle
    // the current node (the cached root, or the node the last read returned)
    // picks a child, and the child's entry is read. In the next cycle the
    // resolve stage inspects that entry: a leaf or a last bit ends the code
    // word, otherwise the entry itself becomes the current node. The read data
    // feeds straight back to the child select, so a bit may follow every cycle.

    logic              at_root_reg, at_root_next;
    node_t             root_reg, root_next;
    logic              s2_valid_reg, s2_valid_next;
    logic              s2_read_reg, s2_read_next;
    logic              s2_last_reg, s2_last_next;
    res_t              s2_res_reg, s2_res_next;

    res_t              queue_reg [QDEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QPTR_W-1:0] count_reg, count_next;

    logic [NODE_W-1:0] ram_rdata;
    node_t             read_node;
    node_t             cur_node;
    node_t             write_node;
    logic              at_root_eff;
    logic [INDEX_W-1:0] next_idx;
    logic              next_ok;
    logic              write_ok;
    logic              accept;
    logic              accept_write;
    logic              accept_bit;
    logic              ram_we;
    logic              ram_re;
    logic              push;
    logic              pop;
    res_t              push_res;

    assign read_node    = node_t'(ram_rdata);
    assign accept       = cmd_valid && cmd_ready;
    assign accept_write = accept && (cmd.op == OP_WRITE);
    assign accept_bit   = accept && (cmd.op == OP_DECODE);

    assign write_node.leaf   = cmd.node_is_leaf;
    assign write_node.symbol = cmd.node_symbol;
    assign write_node.left   = cmd.left_index;
    assign write_node.right  = cmd.right_index;

    assign write_ok = (32'(cmd.node_index) < 32'(TABLE_SIZE));
    assign ram_we   = accept_write && write_ok;

    // Resolve stage: decides the word of the bit accepted last cycle.
    always_comb
    begin
        push        = 1'b0;
        push_res    = '0;
        at_root_eff = at_root_reg;
        if (s2_valid_reg)
        begin
            if (!s2_read_reg)
            begin
                // Word already settled in the accept cycle.
                push        = 1'b1;
                push_res    = s2_res_reg;
                at_root_eff = 1'b1;
            end
            else if (read_node.leaf)
            begin
                push                 = 1'b1;
                push_res.symbol      = read_node.symbol;
                push_res.message_end = s2_last_reg;
                push_res.incomplete  = 1'b0;
                at_root_eff          = 1'b1;
            end
            else if (s2_last_reg)
            begin
                // The message ended inside a code word.
                push                 = 1'b1;
                push_res.symbol      = '0;
                push_res.message_end = 1'b1;
                push_res.incomplete  = 1'b1;
                at_root_eff          = 1'b1;
            end
            else
            begin
                at_root_eff = 1'b0;
            end
        end
    end

    // When the walk is off the root, the read port still holds that node.
    assign cur_node = at_root_eff ? root_reg : read_node;
    assign next_idx = cmd.code_bit ? cur_node.right : cur_node.left;
    assign next_ok  = (32'(next_idx) < 32'(TABLE_SIZE));
    assign ram_re   = accept_bit && !cur_node.leaf && next_ok;

    // Accept stage and walk position.
    always_comb
    begin
        s2_valid_next = accept_bit;
        s2_read_next  = 1'b0;
        s2_last_next  = cmd.last_bit;
        s2_res_next   = '0;
        at_root_next  = at_root_eff;
        root_next     = root_reg;

        if (accept_write)
        begin
            at_root_next = 1'b1;
            if (cmd.node_index == '0)
            begin
                root_next = write_node;
            end
        end
        else if (accept_bit)
        begin
            at_root_next = 1'b0;
            if (cur_node.leaf)
            begin
                // A leaf at the current node gives its symbol on every bit.
                s2_res_next.symbol      = cur_node.symbol;
                s2_res_next.message_end = cmd.last_bit;
                s2_res_next.incomplete  = 1'b0;
            end
            else if (!next_ok)
            begin
                // A child index outside the table aborts the code word.
                s2_res_next.symbol      = '0;
                s2_res_next.message_end = cmd.last_bit;
                s2_res_next.incomplete  = 1'b1;
            end
            else
            begin
                s2_read_next = 1'b1;
            end
        end
    end

    ptbd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (TABLE_SIZE)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(cmd.node_index)),
        .wdata (NODE_W'(write_node)),
        .re    (ram_re),
        .raddr (ADDR_W'(next_idx)),
        .rdata (ram_rdata)
    );

    // Result queue.
    assign res_valid = (count_reg != '0);
    assign res       = queue_reg[head_reg];
    assign pop       = res_valid && res_ready;
    assign cmd_ready = (({1'b0, count_reg} + {2'b00, s2_valid_reg}) <= 3'(QDEPTH - 1));

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = (head_reg == QPTR_W'(QDEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push)
        begin
            tail_next = (tail_reg == QPTR_W'(QDEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_root_reg  <= 1'b1;
            root_reg     <= '0;
            s2_valid_reg <= 1'b0;
            s2_read_reg  <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            at_root_reg  <= at_root_next;
            root_reg     <= root_next;
            s2_valid_reg <= s2_valid_next;
            s2_read_reg  <= s2_read_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg <= s2_last_next;
        s2_res_reg  <= s2_res_next;
        if (push)
        begin
            queue_reg[tail_reg] <= push_res;
        end
    end

endmodule

>>> sv/ptbd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module ptbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // The read data holds its value between reads.
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
